/* src/mvt_pkg.sv */
// ----------------------------------------------------------------------------
// mvt_pkg
// Shared types and constants for the 4x4 matrix times vector transform unit.
// ----------------------------------------------------------------------------
package mvt_pkg;

   localparam int WORD_W    = 32;
   localparam int MAT_DIM   = 4;
   localparam int MAT_ELEMS = MAT_DIM * MAT_DIM;
   localparam int INDEX_W   = 4;

   // Operation codes carried in the request word
   localparam logic OP_LOAD      = 1'b0;
   localparam logic OP_TRANSFORM = 1'b1;

   localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

   typedef logic signed [WORD_W-1:0] word_type;

   typedef struct packed {
      logic                     operation;
      logic [INDEX_W-1:0]       element_index;
      logic signed [WORD_W-1:0] element_value;
      logic signed [WORD_W-1:0] vec_x;
      logic signed [WORD_W-1:0] vec_y;
      logic signed [WORD_W-1:0] vec_z;
      logic signed [WORD_W-1:0] vec_w;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] res_x;
      logic signed [WORD_W-1:0] res_y;
      logic signed [WORD_W-1:0] res_z;
      logic signed [WORD_W-1:0] res_w;
      logic                     overflow;
   } rsp_type;

   // Stage load enables handed from the top level to every lane
   typedef struct packed {
      logic load_prod;
      logic load_pair;
   } lane_ctrl_type;

endpackage

/* src/mvt_matrix_store.sv */
// ----------------------------------------------------------------------------
// mvt_matrix_store
// Sixteen matrix element registers, column-major, reset to the identity.
// ----------------------------------------------------------------------------
module mvt_matrix_store import mvt_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [INDEX_W-1:0] wr_index,
   input  word_type           wr_value,
   output word_type           elem [MAT_ELEMS]
);

   localparam word_type ONE = WORD_W'(1) << FRAC_BITS;

   word_type elem_ff [MAT_ELEMS];

   for (genvar e = 0; e < MAT_ELEMS; e++) begin : g_elem
      // Diagonal sits at column*4 + row with column == row
      localparam word_type RESET_VAL = ((e % (MAT_DIM + 1)) == 0) ? ONE : '0;

      always_ff @(posedge clock) begin
         if (reset) begin
            elem_ff[e] <= RESET_VAL;
         end else if (wr_en && (wr_index == INDEX_W'(e))) begin
            elem_ff[e] <= wr_value;
         end
      end

      assign elem[e] = elem_ff[e];
   end

endmodule

/* src/mvt_lane.sv */
// ----------------------------------------------------------------------------
// mvt_lane
// One output component: four products, floor shift, pairwise add, final add
// and saturation to the signed 32-bit range.
// ----------------------------------------------------------------------------
module mvt_lane import mvt_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic          clock,
   input  lane_ctrl_type ctrl,
   input  word_type      vec  [MAT_DIM],
   input  word_type      row  [MAT_DIM],
   output word_type      result,
   output logic          saturated
);

   localparam int PROD_W = 2 * WORD_W;
   localparam int SHR_W  = PROD_W - FRAC_BITS;
   localparam int PAIR_W = SHR_W + 1;
   localparam int SUM_W  = SHR_W + 2;

   logic signed [PROD_W-1:0] prod_full [MAT_DIM];
   logic signed [SHR_W-1:0]  prod_in   [MAT_DIM];
   logic signed [SHR_W-1:0]  prod_ff   [MAT_DIM];
   logic signed [PAIR_W-1:0] pair_in   [2];
   logic signed [PAIR_W-1:0] pair_ff   [2];
   logic signed [SUM_W-1:0]  total;
   logic                     all_ones;
   logic                     all_zeros;

   // Exact 64-bit products; dropping the low fraction bits floors them
   always_comb begin
      for (int k = 0; k < MAT_DIM; k++) begin
         prod_full[k] = PROD_W'(vec[k]) * PROD_W'(row[k]);
         prod_in[k]   = prod_full[k][PROD_W-1:FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_prod) begin
         prod_ff <= prod_in;
      end
   end

   assign pair_in[0] = PAIR_W'(prod_ff[0]) + PAIR_W'(prod_ff[1]);
   assign pair_in[1] = PAIR_W'(prod_ff[2]) + PAIR_W'(prod_ff[3]);

   always_ff @(posedge clock) begin
      if (ctrl.load_pair) begin
         pair_ff <= pair_in;
      end
   end

   assign total = SUM_W'(pair_ff[0]) + SUM_W'(pair_ff[1]);

   // In range when every bit above the 32-bit sign matches it
   assign all_ones  = &total[SUM_W-1:WORD_W-1];
   assign all_zeros = ~|total[SUM_W-1:WORD_W-1];
   assign saturated = !(all_ones || all_zeros);

   always_comb begin
      if (!saturated) begin
         result = total[WORD_W-1:0];
      end else if (total[SUM_W-1]) begin
         result = WORD_MIN;
      end else begin
         result = WORD_MAX;
      end
   end

endmodule

/* src/mvt_merge.sv */
// ----------------------------------------------------------------------------
// mvt_merge
// Output register: gathers the four lane results and folds their saturation
// flags into one overflow bit.
// ----------------------------------------------------------------------------
module mvt_merge import mvt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  word_type lane_result [MAT_DIM],
   input  logic     lane_sat    [MAT_DIM],
   output logic     ready,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_word
);

   logic    valid_ff;
   rsp_type word_ff;
   rsp_type word_in;

   assign ready = !valid_ff || !rsp_stall;

   always_comb begin
      word_in.res_x    = lane_result[0];
      word_in.res_y    = lane_result[1];
      word_in.res_z    = lane_result[2];
      word_in.res_w    = lane_result[3];
      word_in.overflow = lane_sat[0] | lane_sat[1] | lane_sat[2] | lane_sat[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready) begin
         word_ff <= word_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

/* src/mat4_vector_transform.sv */
// ----------------------------------------------------------------------------
// mat4_vector_transform
// Q16.16 fixed-point 4x4 matrix times 4-vector transform unit.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid / req_stall / req_word) carries one word
//   per item. A load word (operation = load) writes one matrix element at
//   column*4 + row and gives no response. A transform word multiplies the
//   stored matrix by (vec_x, vec_y, vec_z, vec_w) and gives one response
//   word on rsp_valid / rsp_stall / rsp_word.
//   Four lanes, one per output component, each form four 32x32 products,
//   floor them by FRAC_BITS, add in a pairwise tree and saturate; a merge
//   stage registers the four components and the OR of their overflow flags.
//   A transform word passes the product, pair-sum and output registers
//   before it shows on rsp_valid.
//   Throughput: one word per cycle unless stalled, loads and transforms
//   in any mix; a load is seen by a transform accepted in the very next cycle.
//   Reset sets the matrix to the identity and empties the pipeline.
//   When the receiver stalls, the output word holds; the stages behind it
//   keep filling bubbles, and req_stall rises only once every stage is full.
// ----------------------------------------------------------------------------
module mat4_vector_transform import mvt_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

   word_type      elem        [MAT_ELEMS];
   word_type      vec         [MAT_DIM];
   word_type      lane_result [MAT_DIM];
   logic          lane_sat    [MAT_DIM];
   lane_ctrl_type ctrl;
   logic          prod_valid_ff;
   logic          prod_valid_in;
   logic          pair_valid_ff;
   logic          adv_prod;
   logic          adv_pair;
   logic          out_ready;
   logic          req_accept;

   // Advance a stage when it is empty or the stage ahead of it advances
   assign adv_pair   = !pair_valid_ff || out_ready;
   assign adv_prod   = !prod_valid_ff || adv_pair;
   assign req_stall  = !adv_prod;
   assign req_accept = req_valid && adv_prod;

   // Only transform words enter the pipeline; loads drop out after the write
   assign prod_valid_in = req_accept && (req_word.operation == OP_TRANSFORM);

   assign ctrl.load_prod = adv_prod;
   assign ctrl.load_pair = adv_pair;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         pair_valid_ff <= 1'b0;
      end else begin
         if (adv_prod) begin
            prod_valid_ff <= prod_valid_in;
         end
         if (adv_pair) begin
            pair_valid_ff <= prod_valid_ff;
         end
      end
   end

   mvt_matrix_store #(
      .FRAC_BITS (FRAC_BITS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (req_accept && (req_word.operation == OP_LOAD)),
      .wr_index (req_word.element_index),
      .wr_value (req_word.element_value),
      .elem     (elem)
   );

   assign vec[0] = req_word.vec_x;
   assign vec[1] = req_word.vec_y;
   assign vec[2] = req_word.vec_z;
   assign vec[3] = req_word.vec_w;

   // Lane i takes matrix row i: elements i, i+4, i+8, i+12
   for (genvar i = 0; i < MAT_DIM; i++) begin : g_lane
      word_type row [MAT_DIM];

      for (genvar k = 0; k < MAT_DIM; k++) begin : g_tap
         assign row[k] = elem[i + MAT_DIM * k];
      end

      mvt_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock     (clock),
         .ctrl      (ctrl),
         .vec       (vec),
         .row       (row),
         .result    (lane_result[i]),
         .saturated (lane_sat[i])
      );
   end

   mvt_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (pair_valid_ff),
      .lane_result (lane_result),
      .lane_sat    (lane_sat),
      .ready       (out_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word)
   );

   // A load word never occupies a pipeline slot
   a_load_no_slot: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_word.operation == OP_LOAD)) |=> !prod_valid_ff)
      else $error("load word entered the pipeline");

   // A held pair-sum word is never dropped
   a_pair_hold: assert property (@(posedge clock) disable iff (reset)
      (pair_valid_ff && !adv_pair) |=> pair_valid_ff)
      else $error("stalled pair-sum word lost");

   // A new response only follows a filled pair-sum stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(pair_valid_ff))
      else $error("response appeared without a source word");

   // Reset leaves matrix elements 0 and 1 at their identity values
   a_reset_identity: assert property (@(posedge clock)
      reset |=> (elem[0] == (WORD_W'(1) << FRAC_BITS)) && (elem[1] == '0))
      else $error("matrix not identity after reset");

endmodule

/* bench/mat4_vector_transform_tb.sv */
// ----------------------------------------------------------------------------
// mat4_vector_transform_tb
// Self-checking bench for the fixed-point 4x4 matrix times vector unit.
// A queue of request words feeds a bursty driver. A shadow matrix predicts
// every transform response. A monitor checks each response word, field by
// field, against the oldest prediction whenever the receiver takes one.
// ----------------------------------------------------------------------------
module mat4_vector_transform_tb import mvt_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_BITS    = 16;
   localparam int ONE          = 1 << FRAC_BITS;
   localparam int RANDOM_ITEMS = 1050;
   localparam int DRAIN_CYCLES = 8;       // pipeline is three deep, plus margin
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_START   = 600;     // receiver cycle where the long hold-off begins
   localparam int HOLD_LEN     = 300;
   localparam int MAX_PRINTED  = 40;

   typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_word  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_word;

   req_type  pending_req_q [$];
   rsp_type  expected_rsp_q [$];
   word_type mat_shadow [MAT_ELEMS];

   int accepted_count  = 0;
   int total_items     = 0;
   int load_count      = 0;
   int transform_count = 0;
   int checked_count   = 0;
   int overflow_count  = 0;
   int backpress_count = 0;
   int mismatch_count  = 0;
   int cycle_count     = 0;

   mat4_vector_transform #(
      .FRAC_BITS (FRAC_BITS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Prediction: M times v with every product floored by FRAC_BITS, the four
   // floored products summed at full width, then clamped to 32 bits.
   // -------------------------------------------------------------------------
   function automatic rsp_type transform_vector(req_type w);
      longint   vec [4];
      longint   acc;
      word_type comp [4];
      logic     ovf;
      rsp_type  r;
      vec[0] = longint'($signed(w.vec_x));
      vec[1] = longint'($signed(w.vec_y));
      vec[2] = longint'($signed(w.vec_z));
      vec[3] = longint'($signed(w.vec_w));
      ovf    = 1'b0;
      for (int i = 0; i < MAT_DIM; i++) begin
         acc = 0;
         // arithmetic shift of a signed product rounds toward minus infinity
         for (int k = 0; k < MAT_DIM; k++)
            acc += (vec[k] * longint'(mat_shadow[i + MAT_DIM * k])) >>> FRAC_BITS;
         if (acc > longint'(WORD_MAX)) begin
            acc = longint'(WORD_MAX);
            ovf = 1'b1;
         end else if (acc < longint'(WORD_MIN)) begin
            acc = longint'(WORD_MIN);
            ovf = 1'b1;
         end
         comp[i] = word_type'(acc);
      end
      r.res_x    = comp[0];
      r.res_y    = comp[1];
      r.res_z    = comp[2];
      r.res_w    = comp[3];
      r.overflow = ovf;
      return r;
   endfunction

   // Mostly small Q16.16 values so sums stay in range; wide draws add full
   // random patterns and the extremes, which drive saturation.
   function automatic word_type rand_word(bit wide);
      int pick;
      pick = wide ? $urandom_range(0, 9) : 9;
      case (pick)
         0, 1:    return word_type'($urandom);
         2: begin
            case ($urandom_range(0, 5))
               0:       return WORD_MAX;
               1:       return WORD_MIN;
               2:       return word_type'(0);
               3:       return word_type'(1);
               4:       return word_type'(-1);
               default: return word_type'(-ONE);
            endcase
         end
         default: return word_type'(int'($urandom_range(0, 8 * ONE)) - 4 * ONE);
      endcase
   endfunction

   // Unused fields carry random noise; the block must ignore them.
   task automatic queue_load(int idx, word_type value);
      req_type w;
      w               = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      w.operation     = OP_LOAD;
      w.element_index = idx[INDEX_W-1:0];
      w.element_value = value;
      pending_req_q.push_back(w);
   endtask

   task automatic queue_transform(word_type x, word_type y, word_type z, word_type wc);
      req_type w;
      w           = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      w.operation = OP_TRANSFORM;
      w.vec_x     = x;
      w.vec_y     = y;
      w.vec_z     = z;
      w.vec_w     = wc;
      pending_req_q.push_back(w);
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      if (mismatch_count < MAX_PRINTED)
         $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // -------------------------------------------------------------------------
   // Stimulus: directed words first, then well-formed random scenarios.
   // Everything is queued at time zero, before the first clock edge.
   // -------------------------------------------------------------------------
   initial begin : stimulus_proc
      int order [MAT_ELEMS];
      int swap, tmp, n, directed;
      bit wide;

      // Identity after reset: vectors must come back unchanged, extremes too.
      queue_transform(word_type'(ONE), word_type'(-2 * ONE), WORD_MAX, WORD_MIN);
      queue_transform(word_type'(0), word_type'(-1), word_type'(1), word_type'(32'h1234_5678));
      // One load then a transform right behind it.
      queue_load(1, word_type'(ONE));
      queue_transform(word_type'(ONE), word_type'(0), word_type'(0), word_type'(0));
      // Extreme diagonal plus tiny and extreme off-diagonal entries.
      queue_load(0, WORD_MAX);
      queue_load(5, WORD_MIN);
      queue_load(10, word_type'(1));
      queue_load(15, WORD_MAX);
      queue_load(2, WORD_MIN);
      queue_load(7, word_type'(-1));
      queue_load(8, word_type'(-1));
      queue_load(13, WORD_MIN);
      // Positive and negative saturation, floor of small negative products.
      queue_transform(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
      queue_transform(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
      queue_transform(word_type'(-1), word_type'(-1), word_type'(-1), word_type'(-1));
      queue_transform(word_type'(1), word_type'(-ONE), word_type'(3), word_type'(-7));
      queue_transform(word_type'(0), word_type'(0), word_type'(0), word_type'(0));
      queue_load(3, word_type'(-ONE));
      queue_load(12, word_type'(ONE / 2));
      queue_transform(word_type'(ONE), word_type'(-ONE), word_type'(ONE / 2), word_type'(-3));
      directed = pending_req_q.size();

      while (pending_req_q.size() - directed < RANDOM_ITEMS) begin
         wide = ($urandom_range(0, 9) < 4);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               // Whole matrix in shuffled order, sometimes only part of it.
               for (int e = 0; e < MAT_ELEMS; e++)
                  order[e] = e;
               for (int e = MAT_ELEMS - 1; e > 0; e--) begin
                  swap        = $urandom_range(0, e);
                  tmp         = order[e];
                  order[e]    = order[swap];
                  order[swap] = tmp;
               end
               n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAT_ELEMS) : MAT_ELEMS;
               for (int e = 0; e < n; e++)
                  queue_load(order[e], rand_word(wide));
               n = $urandom_range(1, 8);
               for (int t = 0; t < n; t++)
                  queue_transform(rand_word(wide), rand_word(wide),
                                  rand_word(wide), rand_word(wide));
            end
            5, 6, 7: begin
               n = $urandom_range(1, 3);
               for (int t = 0; t < n; t++)
                  queue_load($urandom_range(0, MAT_ELEMS - 1), rand_word(wide));
               n = $urandom_range(1, 3);
               for (int t = 0; t < n; t++)
                  queue_transform(rand_word(wide), rand_word(wide),
                                  rand_word(wide), rand_word(wide));
            end
            default: begin
               // Noise: any mix of loads and transforms.
               n = $urandom_range(1, 10);
               for (int t = 0; t < n; t++) begin
                  if ($urandom_range(0, 1) == 0)
                     queue_load($urandom_range(0, MAT_ELEMS - 1), rand_word(1'b1));
                  else
                     queue_transform(word_type'($urandom), word_type'($urandom),
                                     rand_word(1'b1), rand_word(1'b0));
               end
            end
         endcase
      end
      total_items = pending_req_q.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Hold until every word is taken, every response is back, then drain.
      wait (accepted_count == total_items);
      while (expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d matrix loads and %0d transforms; %0d responses checked, %0d saturated.",
               load_count, transform_count, checked_count, overflow_count);
      $display("Input was back-pressured for %0d cycles; %0d mismatches.",
               backpress_count, mismatch_count);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Driver: bursts of random length separated by random gaps. A stalled word
   // holds until taken. Each accepted word updates the shadow matrix or
   // pushes one predicted response.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : drive_proc
      logic    next_valid;
      req_type next_word;
      int      burst_left;
      int      gap_left;
      if (reset) begin
         for (int e = 0; e < MAT_ELEMS; e++)
            mat_shadow[e] = (e % (MAT_DIM + 1) == 0) ? word_type'(ONE) : word_type'(0);
         burst_left = $urandom_range(1, 40);
         gap_left   = 0;
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         next_word  = req_word;
         if (req_valid && req_stall)
            backpress_count++;
         if (req_valid && !req_stall) begin
            if (req_word.operation == OP_LOAD) begin
               mat_shadow[req_word.element_index] = req_word.element_value;
               load_count++;
            end else begin
               expected_rsp_q.push_back(transform_vector(req_word));
               transform_count++;
            end
            accepted_count++;
            next_valid = 1'b0;
         end
         // Only advance when the current word is gone or there is none.
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_req_q.size() != 0) begin
               next_word  = pending_req_q.pop_front();
               next_valid = 1'b1;
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
         req_valid <= next_valid;
         req_word  <= next_word;
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: stall pattern that changes mode every so often, with one long
   // hold-off so the pipeline fills and pushes back on the sender.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : stall_proc
      logic        next_stall;
      int          rx_cycle;
      int          hold_left;
      rx_mode_type rx_mode;
      if (reset) begin
         rx_cycle   = 0;
         hold_left  = 0;
         rx_mode    = RX_FREE;
         rsp_stall <= 1'b0;
      end else begin
         rx_cycle++;
         if (rx_cycle % 97 == 0)
            rx_mode = rx_mode_type'($urandom_range(0, 3));
         if (hold_left > 0) begin
            hold_left--;
            next_stall = 1'b1;
         end else if (rx_cycle == HOLD_START) begin
            hold_left  = HOLD_LEN - 1;
            next_stall = 1'b1;
         end else begin
            case (rx_mode)
               RX_FREE:  next_stall = 1'b0;
               RX_LIGHT: next_stall = ($urandom_range(0, 3) == 0);
               RX_HEAVY: next_stall = ($urandom_range(0, 9) < 6);
               default:  next_stall = (rx_cycle % 3 == 0);
            endcase
         end
         rsp_stall <= next_stall;
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: every accepted response word is compared with the oldest
   // prediction; a word with nothing pending is an error.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : check_proc
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("response word with none pending, res_x",
                            longint'(rsp_word.res_x), 0);
         end else begin
            want = expected_rsp_q.pop_front();
            checked_count++;
            if (rsp_word.overflow === 1'b1)
               overflow_count++;
            if (rsp_word.res_x !== want.res_x)
               report_mismatch("res_x", longint'(rsp_word.res_x), longint'(want.res_x));
            if (rsp_word.res_y !== want.res_y)
               report_mismatch("res_y", longint'(rsp_word.res_y), longint'(want.res_y));
            if (rsp_word.res_z !== want.res_z)
               report_mismatch("res_z", longint'(rsp_word.res_z), longint'(want.res_z));
            if (rsp_word.res_w !== want.res_w)
               report_mismatch("res_w", longint'(rsp_word.res_w), longint'(want.res_w));
            if (rsp_word.overflow !== want.overflow)
               report_mismatch("overflow", longint'(rsp_word.overflow),
                               longint'(want.overflow));
         end
      end
   end

   // Drop the run if it hangs.
   always @(posedge clock) begin : watchdog_proc
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses still pending",
                  cycle_count, expected_rsp_q.size());
         $display("Some tests failed");
         $finish;
      end
   end

endmodule

/* filelist.f */
src/mvt_pkg.sv
src/mvt_matrix_store.sv
src/mvt_lane.sv
src/mvt_merge.sv
src/mat4_vector_transform.sv
bench/mat4_vector_transform_tb.sv
